// ===== rtl/ogf_pkg.sv =====
// Shared constants, types and codes of the occupancy grid fusion block.
`timescale 1ns / 1ps
package ogf_pkg;

   // Map geometry
   localparam int MAP_WIDTH   = 512;
   localparam int MAP_HEIGHT  = 512;
   localparam int LOCAL_SIDE  = 1024;
   localparam int STORE_DEPTH = 262144;
   localparam int ADDR_W      = 18;
   localparam int MAP_CELLS   = MAP_WIDTH * MAP_HEIGHT;
   localparam int CLEAR_CELLS = (MAP_CELLS < STORE_DEPTH) ? MAP_CELLS : STORE_DEPTH;
   localparam int COL_W       = $clog2(MAP_WIDTH + 1);
   localparam int ROW_W       = $clog2(MAP_HEIGHT + 1);
   localparam int FULL_W      = $clog2(MAP_CELLS + 1);

   // Item field widths
   localparam int LOCAL_W = 10;
   localparam int COST_W  = 8;
   localparam int LEVEL_W = 7;
   localparam int CODE_W  = 3;

   // Affine arithmetic: Q16.16 coefficients times 2*local+1, i.e. 2^-17 resolution
   localparam int COEF_W     = 32;
   localparam int MULT_W     = LOCAL_W + 2;
   localparam int PROD_W     = COEF_W + MULT_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int FRAC_SHIFT = 17;
   localparam int Q_W        = SUM_W - FRAC_SHIFT;

   // Cell codes
   localparam logic signed [COST_W-1:0] OCCUPIED_CODE = 8'sd100;
   localparam logic signed [COST_W-1:0] FREE_CODE     = 8'sd0;
   localparam logic signed [COST_W-1:0] UNKNOWN_CODE  = -8'sd1;
   localparam logic signed [COST_W-1:0] CLAMP_TOP     = 8'sd100;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_COL_FROM_COL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_COL_FROM_ROW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW_FROM_COL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW_FROM_ROW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_COL        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_ROW        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LETHAL_LEVEL      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_LEVEL        = 3'd7;

   // Item function codes
   localparam logic FUNC_FUSE = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [CODE_W-1:0] {
      OUT_SKIPPED = 3'd0,
      OUT_OUTSIDE = 3'd1,
      OUT_WRITTEN = 3'd2,
      OUT_KEPT    = 3'd3,
      OUT_READ    = 3'd4
   } outcome_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] col_from_col;
      logic signed [COEF_W-1:0] col_from_row;
      logic signed [COEF_W-1:0] row_from_col;
      logic signed [COEF_W-1:0] row_from_row;
      logic signed [COEF_W-1:0] offset_col;
      logic signed [COEF_W-1:0] offset_row;
   } affine_type;

   typedef struct packed {
      logic              valid;
      logic              on_map;
      logic [ADDR_W-1:0] index;
   } map_res_type;

endpackage

// ===== rtl/ogf_req_if.sv =====
// Request channel: fuse and read items into the block.
`timescale 1ns / 1ps
interface ogf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic [ogf_pkg::LOCAL_W-1:0]          local_col;
   logic [ogf_pkg::LOCAL_W-1:0]          local_row;
   logic signed [ogf_pkg::COST_W-1:0]    cost;
   logic [ogf_pkg::ADDR_W-1:0]           read_index;

   modport source (output valid, func, local_col, local_row, cost, read_index, input ready);
   modport sink   (input valid, func, local_col, local_row, cost, read_index, output ready);
endinterface

// ===== rtl/ogf_rsp_if.sv =====
// Response channel: one result item per request item.
`timescale 1ns / 1ps
interface ogf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ogf_pkg::CODE_W-1:0]           outcome;
   logic [ogf_pkg::ADDR_W-1:0]           cell_index;
   logic signed [ogf_pkg::COST_W-1:0]    cell_value;

   modport source (output valid, outcome, cell_index, cell_value, input ready);
   modport sink   (input valid, outcome, cell_index, cell_value, output ready);
endinterface

// ===== rtl/ogf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module ogf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/ogf_mapper.sv =====
// Three-stage affine mapper from a local cell centre to a global map index.
`timescale 1ns / 1ps
module ogf_mapper (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ogf_pkg::LOCAL_W-1:0]   local_col,
   input  logic [ogf_pkg::LOCAL_W-1:0]   local_row,
   input  ogf_pkg::affine_type           affine,
   output ogf_pkg::map_res_type          res
);
   logic signed [ogf_pkg::MULT_W-1:0] col_mult;
   logic signed [ogf_pkg::MULT_W-1:0] row_mult;

   logic                              prod_valid_ff;
   logic                              prod_local_ok_ff;
   logic signed [ogf_pkg::PROD_W-1:0] prod_cc_ff;
   logic signed [ogf_pkg::PROD_W-1:0] prod_cr_ff;
   logic signed [ogf_pkg::PROD_W-1:0] prod_rc_ff;
   logic signed [ogf_pkg::PROD_W-1:0] prod_rr_ff;

   logic                              sum_valid_ff;
   logic                              sum_local_ok_ff;
   logic signed [ogf_pkg::SUM_W-1:0]  sum_col_ff;
   logic signed [ogf_pkg::SUM_W-1:0]  sum_row_ff;

   logic [ogf_pkg::Q_W-1:0]           col_q;
   logic [ogf_pkg::Q_W-1:0]           row_q;
   logic                              col_ok;
   logic                              row_ok;
   logic [ogf_pkg::FULL_W-1:0]        full_index;

   logic                              res_valid_ff;
   logic                              res_inside_ff;
   logic [ogf_pkg::ADDR_W-1:0]        res_index_ff;

   // Cell centre doubled: 2*local+1, kept positive in a signed operand
   assign col_mult = $signed({1'b0, local_col, 1'b1});
   assign row_mult = $signed({1'b0, local_row, 1'b1});

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= start;
         sum_valid_ff  <= prod_valid_ff;
         res_valid_ff  <= sum_valid_ff;
      end
      if (start) begin
         prod_local_ok_ff <= (32'(local_col) < ogf_pkg::LOCAL_SIDE) &&
                             (32'(local_row) < ogf_pkg::LOCAL_SIDE);
         prod_cc_ff <= affine.col_from_col * col_mult;
         prod_cr_ff <= affine.col_from_row * row_mult;
         prod_rc_ff <= affine.row_from_col * col_mult;
         prod_rr_ff <= affine.row_from_row * row_mult;
      end
      sum_local_ok_ff <= prod_local_ok_ff;
      sum_col_ff <= ogf_pkg::SUM_W'(prod_cc_ff) + ogf_pkg::SUM_W'(prod_cr_ff) +
                    (ogf_pkg::SUM_W'(affine.offset_col) <<< 1);
      sum_row_ff <= ogf_pkg::SUM_W'(prod_rc_ff) + ogf_pkg::SUM_W'(prod_rr_ff) +
                    (ogf_pkg::SUM_W'(affine.offset_row) <<< 1);
      res_inside_ff <= sum_local_ok_ff && col_ok && row_ok &&
                       (32'(full_index) < ogf_pkg::STORE_DEPTH);
      res_index_ff  <= ogf_pkg::ADDR_W'(full_index);
   end

   // Floor of a non-negative sum is the integer part above the fraction bits
   always_comb begin
      col_q  = sum_col_ff[ogf_pkg::SUM_W-1:ogf_pkg::FRAC_SHIFT];
      row_q  = sum_row_ff[ogf_pkg::SUM_W-1:ogf_pkg::FRAC_SHIFT];
      col_ok = !sum_col_ff[ogf_pkg::SUM_W-1] && (col_q < ogf_pkg::Q_W'(ogf_pkg::MAP_WIDTH));
      row_ok = !sum_row_ff[ogf_pkg::SUM_W-1] && (row_q < ogf_pkg::Q_W'(ogf_pkg::MAP_HEIGHT));
      full_index = ogf_pkg::FULL_W'(row_q[ogf_pkg::ROW_W-1:0]) *
                   ogf_pkg::FULL_W'(ogf_pkg::MAP_WIDTH) +
                   ogf_pkg::FULL_W'(col_q[ogf_pkg::COL_W-1:0]);
   end

   assign res.valid  = res_valid_ff;
   assign res.on_map = res_inside_ff;
   assign res.index  = res_index_ff;
endmodule

// ===== rtl/occupancy_grid_fusion.sv =====
// Top level of the occupancy grid fusion block: control, map store and result register.
`timescale 1ns / 1ps
// Usage
//   req: valid/ready channel of items. func FUSE maps (local_col, local_row)
//     through the Q16.16 affine map and folds cost into that global cell;
//     func READ returns the cell at read_index.
//   rsp: valid/ready channel, exactly one result item per request item, in
//     order: outcome, cell_index and the cell value after the item.
//   csr: write-only register port (csr_write_en, csr_index, csr_wdata); write
//     only while no item is in flight.
// Sequence
//   One item at a time around a single map RAM. An on-map fuse item passes
//   the mapper pipeline, index capture, RAM read, then update and result
//   load; an off-map fuse item skips the RAM read, a read item starts at the
//   RAM read and a fuse item with an unknown cost goes straight to the result
//   load. The next item is accepted the cycle after the result load, not
//   before. Each item writes back before the next reads the RAM.
// Reset
//   Synchronous reset loads the register defaults and runs a clearing pass
//   that writes unknown (-1) into all 262144 cells, one per cycle; req.ready
//   stays low until the pass ends. CSR writes are taken meanwhile.
// Stall
//   A result waits in the output register while rsp.ready is low; the block
//   still takes and works the next item, and holds it before loading.
module occupancy_grid_fusion (
   input  logic                             clock,
   input  logic                             reset,
   ogf_req_if.sink                          req,
   ogf_rsp_if.source                        rsp,
   input  logic                             csr_write_en,
   input  logic [ogf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ogf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_ADDR,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_OUTSIDE,
      KIND_FUSE,
      KIND_READ
   } kind_type;

   // Control and configuration registers
   state_type                          state_ff;
   logic [ogf_pkg::ADDR_W-1:0]         clear_addr_ff;
   kind_type                           kind_ff;
   logic signed [ogf_pkg::COST_W-1:0]  cost_ff;
   logic [ogf_pkg::ADDR_W-1:0]         idx_ff;
   logic                               hit_ff;
   ogf_pkg::affine_type                affine_ff;
   logic [ogf_pkg::LEVEL_W-1:0]        lethal_ff;
   logic [ogf_pkg::LEVEL_W-1:0]        free_ff;

   // Result register
   logic                               rsp_valid_ff;
   ogf_pkg::outcome_type               rsp_outcome_ff;
   logic [ogf_pkg::ADDR_W-1:0]         rsp_index_ff;
   logic signed [ogf_pkg::COST_W-1:0]  rsp_value_ff;

   // Next-value and datapath signals
   logic                               req_accept;
   logic                               map_start;
   ogf_pkg::map_res_type               map_res;
   logic                               rsp_load;
   ogf_pkg::outcome_type               outcome_in;
   logic [ogf_pkg::ADDR_W-1:0]         index_in;
   logic signed [ogf_pkg::COST_W-1:0]  value_in;
   logic signed [ogf_pkg::COST_W-1:0]  cur_value;
   logic                               mem_we;
   logic [ogf_pkg::ADDR_W-1:0]         mem_waddr;
   logic signed [ogf_pkg::COST_W-1:0]  mem_wdata;
   logic                               mem_re;
   logic [ogf_pkg::ADDR_W-1:0]         clear_last;

   assign clear_last = ogf_pkg::ADDR_W'(ogf_pkg::CLEAR_CELLS - 1);

   // Take a new item only when the sequencer is free
   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign map_start  = req_accept && (req.func == ogf_pkg::FUNC_FUSE) && !req.cost[ogf_pkg::COST_W-1];

   // Load the result once the output register is free or being drained
   assign rsp_load = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp.ready);

   ogf_mapper u_mapper (
      .clock     (clock),
      .reset     (reset),
      .start     (map_start),
      .local_col (req.local_col),
      .local_row (req.local_row),
      .affine    (affine_ff),
      .res       (map_res)
   );

   logic [ogf_pkg::COST_W-1:0] mem_rdata;

   ogf_ram #(
      .WIDTH (ogf_pkg::COST_W),
      .DEPTH (ogf_pkg::STORE_DEPTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (idx_ff),
      .rd_data (mem_rdata)
   );

   assign cur_value = $signed(mem_rdata);

   // Fold the cost into the current cell value; lethal wins over free
   always_comb begin
      outcome_in = ogf_pkg::OUT_SKIPPED;
      index_in   = '0;
      value_in   = '0;
      case (kind_ff)
         KIND_SKIP: begin
            outcome_in = ogf_pkg::OUT_SKIPPED;
         end
         KIND_OUTSIDE: begin
            outcome_in = ogf_pkg::OUT_OUTSIDE;
         end
         KIND_READ: begin
            outcome_in = ogf_pkg::OUT_READ;
            index_in   = idx_ff;
            value_in   = hit_ff ? cur_value : ogf_pkg::UNKNOWN_CODE;
         end
         KIND_FUSE: begin
            index_in = idx_ff;
            if (cost_ff[ogf_pkg::LEVEL_W-1:0] >= lethal_ff) begin
               outcome_in = ogf_pkg::OUT_WRITTEN;
               value_in   = ogf_pkg::OCCUPIED_CODE;
            end else if (cost_ff[ogf_pkg::LEVEL_W-1:0] <= free_ff) begin
               outcome_in = ogf_pkg::OUT_WRITTEN;
               value_in   = ogf_pkg::FREE_CODE;
            end else if ((cur_value == ogf_pkg::UNKNOWN_CODE) || (cost_ff > cur_value)) begin
               outcome_in = ogf_pkg::OUT_WRITTEN;
               value_in   = (cost_ff > ogf_pkg::CLAMP_TOP) ? ogf_pkg::CLAMP_TOP : cost_ff;
            end else begin
               outcome_in = ogf_pkg::OUT_KEPT;
               value_in   = cur_value;
            end
         end
         default: begin
            outcome_in = ogf_pkg::OUT_SKIPPED;
         end
      endcase
   end

   // RAM ports: the clearing pass owns the write port until it ends
   always_comb begin
      mem_re = (state_ff == ST_ADDR);
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clear_addr_ff;
         mem_wdata = ogf_pkg::UNKNOWN_CODE;
      end else begin
         mem_we    = rsp_load && (kind_ff == KIND_FUSE) && (outcome_in == ogf_pkg::OUT_WRITTEN);
         mem_waddr = idx_ff;
         mem_wdata = value_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         affine_ff.col_from_col <= 32'sd65536;
         affine_ff.col_from_row <= '0;
         affine_ff.row_from_col <= '0;
         affine_ff.row_from_row <= 32'sd65536;
         affine_ff.offset_col   <= '0;
         affine_ff.offset_row   <= '0;
         lethal_ff <= 7'd70;
         free_ff   <= 7'd20;
      end else if (csr_write_en) begin
         case (csr_index)
            ogf_pkg::CSR_COEF_COL_FROM_COL: affine_ff.col_from_col <= $signed(csr_wdata);
            ogf_pkg::CSR_COEF_COL_FROM_ROW: affine_ff.col_from_row <= $signed(csr_wdata);
            ogf_pkg::CSR_COEF_ROW_FROM_COL: affine_ff.row_from_col <= $signed(csr_wdata);
            ogf_pkg::CSR_COEF_ROW_FROM_ROW: affine_ff.row_from_row <= $signed(csr_wdata);
            ogf_pkg::CSR_OFFSET_COL:        affine_ff.offset_col   <= $signed(csr_wdata);
            ogf_pkg::CSR_OFFSET_ROW:        affine_ff.offset_row   <= $signed(csr_wdata);
            ogf_pkg::CSR_LETHAL_LEVEL:      lethal_ff <= csr_wdata[ogf_pkg::LEVEL_W-1:0];
            ogf_pkg::CSR_FREE_LEVEL:        free_ff   <= csr_wdata[ogf_pkg::LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clear_addr_ff <= clear_addr_ff + 1'b1;
               if (clear_addr_ff == clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  if (req.func == ogf_pkg::FUNC_READ) begin
                     state_ff <= ST_ADDR;
                  end else if (req.cost[ogf_pkg::COST_W-1]) begin
                     state_ff <= ST_UPDATE;
                  end else begin
                     state_ff <= ST_MAP;
                  end
               end
            end
            ST_MAP: begin
               // Hold until the mapper delivers; drop straight to result if off map
               if (map_res.valid) begin
                  state_ff <= map_res.on_map ? ST_ADDR : ST_UPDATE;
               end
            end
            ST_ADDR: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      // Item payload; no reset needed
      if (req_accept) begin
         cost_ff <= req.cost;
         idx_ff  <= req.read_index;
         hit_ff  <= (32'(req.read_index) < ogf_pkg::CLEAR_CELLS);
         if (req.func == ogf_pkg::FUNC_READ) begin
            kind_ff <= KIND_READ;
         end else if (req.cost[ogf_pkg::COST_W-1]) begin
            kind_ff <= KIND_SKIP;
         end else begin
            kind_ff <= KIND_FUSE;
         end
      end else if ((state_ff == ST_MAP) && map_res.valid) begin
         idx_ff  <= map_res.index;
         kind_ff <= map_res.on_map ? KIND_FUSE : KIND_OUTSIDE;
      end
      if (rsp_load) begin
         rsp_outcome_ff <= outcome_in;
         rsp_index_ff   <= index_in;
         rsp_value_ff   <= value_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.outcome    = rsp_outcome_ff;
   assign rsp.cell_index = rsp_index_ff;
   assign rsp.cell_value = rsp_value_ff;

   // The mapper only reports while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      map_res.valid |-> (state_ff == ST_MAP))
      else $error("mapper result outside map wait");

   // An accepted item keeps the sequencer busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE) && (state_ff != ST_CLEAR))
      else $error("sequencer idle after accept");

   // Map writes after the clearing pass come only from a fuse item
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff != ST_CLEAR)) |-> (kind_ff == KIND_FUSE) && rsp_load)
      else $error("map write without fuse item");

   // A written cell always holds a value in 0..100
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (outcome_in == ogf_pkg::OUT_WRITTEN)) |->
         ((value_in >= ogf_pkg::FREE_CODE) && (value_in <= ogf_pkg::CLAMP_TOP)))
      else $error("written cell value out of range");
endmodule

// ===== tb/tb_occupancy_grid_fusion.sv =====
// Self-checking testbench: fuse/read traffic against a cycle-free map predictor.
`timescale 1ns / 1ps
module tb_occupancy_grid_fusion;
   import ogf_pkg::*;

   // One request item as driven on the req channel
   typedef struct {
      logic                     func;
      logic [LOCAL_W-1:0]       col;
      logic [LOCAL_W-1:0]       row;
      logic signed [COST_W-1:0] cost;
      logic [ADDR_W-1:0]        read_index;
   } grid_item_type;

   // One result item as the block should return it
   typedef struct {
      outcome_type              outcome;
      logic [ADDR_W-1:0]        index;
      logic signed [COST_W-1:0] value;
   } cell_result_type;

   // Receiver hold-off: after this many results, drop ready for a long stretch
   localparam int HOLD_AT_RESULT = 150;
   localparam int HOLD_CYCLES    = 300;
   localparam int IDLE_PCT       = 37;
   localparam int TAIL_CYCLES    = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ogf_req_if req_ch ();
   ogf_rsp_if rsp_ch ();

   occupancy_grid_fusion uut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: own copy of the cost map and of the register settings
   logic signed [COST_W-1:0] cost_map [0:STORE_DEPTH-1];
   affine_type               map_xf;
   logic [LEVEL_W-1:0]       lethal_lvl;
   logic [LEVEL_W-1:0]       free_lvl;
   int unsigned              touched_cells[$];

   grid_item_type   pending_items[$];
   cell_result_type expected_cells[$];
   grid_item_type   on_wire;

   bit calm = 1'b0;
   int fail_count = 0;
   int results_seen = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int hot_col = 0;
   int hot_row = 0;

   // Floor of one affine axis at 2^-17 resolution; false when off the map
   function automatic bit to_global(input logic signed [COEF_W-1:0] gain_c,
                                    input logic signed [COEF_W-1:0] gain_r,
                                    input logic signed [COEF_W-1:0] ofs,
                                    input longint mc, input longint mr,
                                    input longint limit, output int coord);
      longint gc;
      longint gr;
      longint go;
      longint acc;
      longint whole;
      gc = longint'(gain_c);
      gr = longint'(gain_r);
      go = longint'(ofs);
      acc = gc * mc + gr * mr + go * 2;
      coord = 0;
      if (acc < 0) return 1'b0;
      whole = acc >>> FRAC_SHIFT;
      if (whole >= limit) return 1'b0;
      coord = int'(whole);
      return 1'b1;
   endfunction

   // Work out the result of one accepted item and update the predicted map
   function automatic cell_result_type fuse_into_map(input grid_item_type it);
      cell_result_type r;
      int gc;
      int gr;
      int cst;
      int cur;
      int val;
      int unsigned idx;
      longint mc;
      longint mr;
      r.outcome = OUT_SKIPPED;
      r.index   = '0;
      r.value   = '0;
      if (it.func == FUNC_READ) begin
         r.outcome = OUT_READ;
         r.index   = it.read_index;
         r.value   = (it.read_index < MAP_CELLS) ? cost_map[it.read_index] : UNKNOWN_CODE;
         return r;
      end
      cst = int'(it.cost);
      if (cst < 0) return r;
      mc = 2 * longint'(it.col) + 1;
      mr = 2 * longint'(it.row) + 1;
      if (it.col >= LOCAL_SIDE || it.row >= LOCAL_SIDE ||
          !to_global(map_xf.col_from_col, map_xf.col_from_row, map_xf.offset_col,
                     mc, mr, MAP_WIDTH, gc) ||
          !to_global(map_xf.row_from_col, map_xf.row_from_row, map_xf.offset_row,
                     mc, mr, MAP_HEIGHT, gr)) begin
         r.outcome = OUT_OUTSIDE;
         return r;
      end
      idx = gr * MAP_WIDTH + gc;
      if (idx >= STORE_DEPTH) begin
         r.outcome = OUT_OUTSIDE;
         return r;
      end
      cur = int'(cost_map[idx]);
      r.outcome = OUT_WRITTEN;
      // lethal wins over free when the two levels overlap
      if (cst >= int'(lethal_lvl))
         val = int'(OCCUPIED_CODE);
      else if (cst <= int'(free_lvl))
         val = int'(FREE_CODE);
      else if (cur == UNKNOWN_CODE || cst > cur)
         val = (cst > CLAMP_TOP) ? int'(CLAMP_TOP) : cst;
      else begin
         val = cur;
         r.outcome = OUT_KEPT;
      end
      cost_map[idx] = val[COST_W-1:0];
      touched_cells.push_back(idx);
      if (touched_cells.size() > 64) void'(touched_cells.pop_front());
      r.index = idx[ADDR_W-1:0];
      r.value = val[COST_W-1:0];
      return r;
   endfunction

   function automatic void queue_item(input logic func, input int col, input int row,
                                      input int cost, input int ridx);
      grid_item_type it;
      it.func       = func;
      it.col        = col[LOCAL_W-1:0];
      it.row        = row[LOCAL_W-1:0];
      it.cost       = cost[COST_W-1:0];
      it.read_index = ridx[ADDR_W-1:0];
      pending_items.push_back(it);
   endfunction

   // Mostly fuse items around a hotspot so cells get revisited; some reads and noise
   function automatic grid_item_type random_item();
      grid_item_type it;
      int pick;
      it.func       = FUNC_FUSE;
      it.col        = LOCAL_W'($urandom);
      it.row        = LOCAL_W'($urandom);
      it.cost       = COST_W'($urandom);
      it.read_index = ADDR_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         it.func = FUNC_READ;
         if (touched_cells.size() != 0 && $urandom_range(0, 1) == 1)
            it.read_index =
               ADDR_W'(touched_cells[$urandom_range(0, touched_cells.size() - 1)]);
      end else begin
         if (pick < 75) begin
            it.col = LOCAL_W'(hot_col + int'($urandom_range(0, 3)));
            it.row = LOCAL_W'(hot_row + int'($urandom_range(0, 3)));
         end else if (pick < 88) begin
            it.col = LOCAL_W'($urandom_range(0, 511));
            it.row = LOCAL_W'($urandom_range(0, 511));
         end
         if ($urandom_range(0, 99) < 85) it.cost = COST_W'($urandom_range(0, 127));
      end
      return it;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
   endtask

   // Program every register, then mirror the settings into the predictor
   task automatic load_settings(input affine_type xf, input logic [LEVEL_W-1:0] lethal,
                                input logic [LEVEL_W-1:0] free_lv);
      write_reg(CSR_COEF_COL_FROM_COL, xf.col_from_col);
      write_reg(CSR_COEF_COL_FROM_ROW, xf.col_from_row);
      write_reg(CSR_COEF_ROW_FROM_COL, xf.row_from_col);
      write_reg(CSR_COEF_ROW_FROM_ROW, xf.row_from_row);
      write_reg(CSR_OFFSET_COL, xf.offset_col);
      write_reg(CSR_OFFSET_ROW, xf.offset_row);
      write_reg(CSR_LETHAL_LEVEL, CSR_DATA_W'(lethal));
      write_reg(CSR_FREE_LEVEL, CSR_DATA_W'(free_lv));
      @(posedge clock);
      csr_write_en <= 1'b0;
      map_xf     = xf;
      lethal_lvl = lethal;
      free_lvl   = free_lv;
   endtask

   // Hold until every queued item is accepted and every result has come back
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_ch.valid || expected_cells.size() != 0)
         @(negedge clock);
   endtask

   // Random transform that roughly centers local (256,256) on global (256,256)
   task automatic run_random_phase(input int count);
      affine_type xf;
      longint gcc;
      longint gcr;
      longint grc;
      longint grr;
      longint oc;
      longint orow;
      gcc = int'($urandom_range(0, 32'h24000)) - 32'sh12000;
      gcr = int'($urandom_range(0, 32'h24000)) - 32'sh12000;
      grc = int'($urandom_range(0, 32'h24000)) - 32'sh12000;
      grr = int'($urandom_range(0, 32'h24000)) - 32'sh12000;
      oc   = (longint'(256) << 16) - (gcc + gcr) * 256 + int'($urandom_range(0, 32'h3FFFFF))
             - 32'sh200000;
      orow = (longint'(256) << 16) - (grc + grr) * 256 + int'($urandom_range(0, 32'h3FFFFF))
             - 32'sh200000;
      xf.col_from_col = gcc[31:0];
      xf.col_from_row = gcr[31:0];
      xf.row_from_col = grc[31:0];
      xf.row_from_row = grr[31:0];
      xf.offset_col   = oc[31:0];
      xf.offset_row   = orow[31:0];
      load_settings(xf, LEVEL_W'($urandom_range(40, 127)), LEVEL_W'($urandom_range(0, 60)));
      hot_col = int'($urandom_range(0, 1020));
      hot_row = int'($urandom_range(0, 1020));
      repeat (count) pending_items.push_back(random_item());
      wait_idle();
   endtask

   // Driver: present the next pending item, predict it on acceptance
   always @(posedge clock) begin
      grid_item_type next_item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_cells.push_back(fuse_into_map(on_wire));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               next_item = pending_items.pop_front();
               on_wire   = next_item;
               req_ch.valid      <= 1'b1;
               req_ch.func       <= next_item.func;
               req_ch.local_col  <= next_item.col;
               req_ch.local_row  <= next_item.row;
               req_ch.cost       <= next_item.cost;
               req_ch.read_index <= next_item.read_index;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result against the oldest expectation
   always @(posedge clock) begin
      cell_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_cells.size() == 0) begin
               $display("%0t: result with none expected: outcome %0d index %0d value %0d",
                        $time, rsp_ch.outcome, rsp_ch.cell_index, rsp_ch.cell_value);
               fail_count++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_ch.outcome !== want.outcome) begin
                  $display("%0t: outcome mismatch, expected %0d, got %0d",
                           $time, want.outcome, rsp_ch.outcome);
                  fail_count++;
               end
               if (rsp_ch.cell_index !== want.index) begin
                  $display("%0t: cell_index mismatch, expected %0d, got %0d",
                           $time, want.index, rsp_ch.cell_index);
                  fail_count++;
               end
               if (rsp_ch.cell_value !== want.value) begin
                  $display("%0t: cell_value mismatch, expected %0d, got %0d",
                           $time, want.value, rsp_ch.cell_value);
                  fail_count++;
               end
            end
         end
         // Long hold-off once, so the block backs up and stalls its input
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Stimulus and end of run
   initial begin
      affine_type xf;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_FUSE;
      req_ch.local_col  = '0;
      req_ch.local_row  = '0;
      req_ch.cost       = '0;
      req_ch.read_index = '0;
      rsp_ch.ready      = 1'b0;
      csr_write_en      = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      for (int i = 0; i < STORE_DEPTH; i++) cost_map[i] = UNKNOWN_CODE;
      map_xf.col_from_col = 32'sh10000;
      map_xf.col_from_row = '0;
      map_xf.row_from_col = '0;
      map_xf.row_from_row = 32'sh10000;
      map_xf.offset_col   = '0;
      map_xf.offset_row   = '0;
      lethal_lvl = 7'd70;
      free_lvl   = 7'd20;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: identity map, lethal 70, free 20
      queue_item(FUNC_FUSE, 0, 0, 50, 0);       // unknown cell takes the cost
      queue_item(FUNC_FUSE, 0, 0, 30, 0);       // lower cost keeps the cell
      queue_item(FUNC_FUSE, 0, 0, 60, 0);       // higher cost overwrites
      queue_item(FUNC_FUSE, 0, 0, 70, 0);       // at lethal level
      queue_item(FUNC_FUSE, 0, 0, 20, 0);       // at free level
      queue_item(FUNC_FUSE, 511, 511, 127, 0);  // last map cell
      queue_item(FUNC_FUSE, 512, 3, 50, 0);     // column past the map
      queue_item(FUNC_FUSE, 3, 1023, 50, 0);    // row past the map
      queue_item(FUNC_FUSE, 1023, 1023, -128, 0);
      queue_item(FUNC_FUSE, 5, 5, -1, 0);       // unknown cost is skipped
      queue_item(FUNC_READ, 0, 0, 0, 0);
      queue_item(FUNC_READ, 1023, 1023, -1, 262143);  // unused fields all ones
      queue_item(FUNC_READ, 0, 0, 0, 1000);     // never written: still unknown
      wait_idle();

      // Half scale with fractional offsets; lethal 127, free 0 exposes the clamp
      xf.col_from_col = 32'sh8000;
      xf.col_from_row = '0;
      xf.row_from_col = '0;
      xf.row_from_row = 32'sh8000;
      xf.offset_col   = 32'sh000A4000;
      xf.offset_row   = 32'sh0003C000;
      load_settings(xf, 7'd127, 7'd0);
      queue_item(FUNC_FUSE, 0, 0, 120, 0);      // clamp to 100
      queue_item(FUNC_FUSE, 0, 0, 127, 0);
      queue_item(FUNC_FUSE, 2, 2, 0, 0);
      queue_item(FUNC_FUSE, 4, 4, 1, 0);
      queue_item(FUNC_FUSE, 1023, 1023, 90, 0);
      hot_col = 100;
      hot_row = 200;
      repeat (60) pending_items.push_back(random_item());
      wait_idle();

      // Quarter turn with a negative gain; lethal below free
      xf.col_from_col = '0;
      xf.col_from_row = -32'sh10000;
      xf.row_from_col = 32'sh10000;
      xf.row_from_row = '0;
      xf.offset_col   = 32'sh02000000;
      xf.offset_row   = '0;
      load_settings(xf, 7'd10, 7'd50);
      queue_item(FUNC_FUSE, 0, 0, 30, 0);       // overlap: lethal test comes first
      queue_item(FUNC_FUSE, 1, 0, 5, 0);
      queue_item(FUNC_FUSE, 0, 600, 40, 0);     // negative column
      hot_col = 300;
      hot_row = 20;
      repeat (60) pending_items.push_back(random_item());
      wait_idle();

      // Extreme gains and offsets: sums far outside the map either way
      xf.col_from_col = 32'sh7FFFFFFF;
      xf.col_from_row = 32'sh80000000;
      xf.row_from_col = 32'sh80000000;
      xf.row_from_row = 32'sh7FFFFFFF;
      xf.offset_col   = 32'sh7FFFFFFF;
      xf.offset_row   = 32'sh80000000;
      load_settings(xf, 7'd0, 7'd127);
      queue_item(FUNC_FUSE, 0, 0, 0, 0);
      queue_item(FUNC_FUSE, 1023, 0, 127, 0);
      repeat (30) pending_items.push_back(random_item());
      wait_idle();

      // Zero gains: every fuse lands on the one offset cell
      xf.col_from_col = '0;
      xf.col_from_row = '0;
      xf.row_from_col = '0;
      xf.row_from_row = '0;
      xf.offset_col   = 32'sh01FF8000;
      xf.offset_row   = 32'sh00008000;
      load_settings(xf, 7'd127, 7'd127);
      queue_item(FUNC_FUSE, 9, 9, 126, 0);      // free level at its top
      repeat (40) pending_items.push_back(random_item());
      wait_idle();

      // Random settings; one phase runs without any idling on either side
      for (int p = 0; p < 6; p++) begin
         calm = (p == 3);
         run_random_phase(105);
      end
      calm = 1'b0;

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_cells.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: the clearing pass alone writes all 262144 cells
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
